// ===== rtl/pngse_pkg.sv =====
// ----------------------------------------------------------------------------
// pngse_pkg
// Shared types and constants of the stored-deflate PNG stream encoder.
// ----------------------------------------------------------------------------
package pngse_pkg;

  // Configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Checksum constants
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // Most bytes delivered for one input transaction
  localparam logic [5:0] OUT_LIMIT = 6'd52;

  // Control of the checksum unit for one byte
  typedef struct packed {
    logic crc_en;    // fold the byte into the CRC-32
    logic crc_init;  // start the CRC-32 from all ones before this byte
    logic adler_en;  // fold the byte into the Adler-32
  } sum_ctl_t;

endpackage

// ===== rtl/pngse_sum.sv =====
// ----------------------------------------------------------------------------
// pngse_sum
// Running CRC-32 of the chunk bytes and Adler-32 of the raw image bytes,
// one byte per enabled cycle.
// ----------------------------------------------------------------------------
module pngse_sum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  pngse_pkg::sum_ctl_t ctl,
  input  logic [7:0]          data,
  output logic [31:0]         crc,
  output logic [31:0]         adler
);
  import pngse_pkg::*;

  logic [31:0] crc_r, crc_nxt;
  logic [15:0] low_r, low_nxt, high_r, high_nxt;
  logic [16:0] low_sum, high_sum;

  // Byte-wise CRC-32, reflected polynomial
  always_comb begin
    crc_nxt = (ctl.crc_init ? CRC_ONES : crc_r) ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      crc_nxt = crc_nxt[0] ? ((crc_nxt >> 1) ^ CRC_POLY) : (crc_nxt >> 1);
    end
  end

  // Adler-32 sums, each reduced by one conditional subtraction
  always_comb begin
    low_sum  = {1'b0, low_r} + {9'd0, data};
    low_nxt  = (low_sum >= ADLER_MOD) ? 16'(low_sum - ADLER_MOD) : low_sum[15:0];
    high_sum = {1'b0, high_r} + {1'b0, low_nxt};
    high_nxt = (high_sum >= ADLER_MOD) ? 16'(high_sum - ADLER_MOD) : high_sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CRC_ONES;
      low_r  <= 16'd1;
      high_r <= 16'd0;
    end else if (en) begin
      if (ctl.crc_en) begin
        crc_r <= crc_nxt;
      end
      if (ctl.adler_en) begin
        low_r  <= low_nxt;
        high_r <= high_nxt;
      end
    end
  end

  assign crc   = crc_r;
  assign adler = {high_r, low_r};

endmodule

// ===== rtl/png_stored_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// png_stored_stream_encoder
// Turns RGB pixels in raster order into the bytes of an uncompressed PNG file.
// ----------------------------------------------------------------------------
// Every byte of the file leaves through one output register at most one byte
// a cycle, and each byte passes the single shared checksum unit. Each pixel
// causes three bytes, four at the start of a row, and five more where a
// stored block begins. The first pixel first runs the length calculation
// (a multiply for the raw length, a reciprocal multiply for the stored block
// count, then a sum) and then the 43 header bytes; the last pixel adds 20
// trailer bytes. No more than 52 bytes are delivered per input transaction;
// what remains is held and is delivered after the next transaction, as is the
// rest of the file after the last pixel. The input is stalled while the bytes
// of a transaction are being produced, unless a full burst of 52 has gone out.
module png_stored_stream_encoder #(
  parameter int MAX_WIDTH   = 4096,
  parameter int MAX_HEIGHT  = 4096,
  parameter int BLOCK_BYTES = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_of_item,
  output logic        out_file_done
);
  import pngse_pkg::*;

  localparam int WLIM    = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;
  localparam int HLIM    = (MAX_HEIGHT > 8191) ? 8191 : MAX_HEIGHT;
  localparam int RAW_MAX = HLIM * (1 + 3 * WLIM);
  localparam int RAW_W   = $clog2(RAW_MAX + 1);
  localparam int BW      = $clog2(BLOCK_BYTES + 1);
  // Reciprocal of the block size, exact for every dividend below 2**XW
  localparam int XW      = ((RAW_W > BW) ? RAW_W : BW) + 1;
  localparam int SH      = XW + BW;
  localparam int MW      = XW + 2;
  localparam logic [63:0] RECIP =
    ((64'd1 << SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
  localparam logic [MW-1:0] RECIP_M = MW'(RECIP);
  localparam logic [12:0] W_MAX = 13'(WLIM);
  localparam logic [12:0] H_MAX = 13'(HLIM);
  localparam logic [BW-1:0] BOFF_LAST = BW'(BLOCK_BYTES - 1);
  localparam logic [RAW_W-1:0] BLK_R = RAW_W'(BLOCK_BYTES);
  localparam logic [5:0] HDR_LAST   = 6'd42;
  localparam logic [5:0] CLOSE_LAST = 6'd19;
  localparam logic [2:0] BHDR_DONE  = 3'd5;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL   = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_SUM   = 7'b0001000,
    ST_HDR   = 7'b0010000,
    ST_RAW   = 7'b0100000,
    ST_CLOSE = 7'b1000000
  } state_t;

  state_t state_r;
  logic [5:0]  idx_r, step_cnt_r;
  logic [2:0]  bhdr_r;
  logic [1:0]  sel_r;
  logic        paused_r, started_r, finished_r, last_px_r, pend_v_r;
  logic [7:0]  red_r, green_r, blue_r, pred_r, pgreen_r, pblue_r;
  logic [12:0] col_r, row_r, width_r, height_r;
  logic [RAW_W-1:0] raw_len_r, left_r;
  logic [XW-1:0]    dv_r;
  logic [BW-1:0]    boff_r;
  logic [31:0]      idat_r;
  logic             out_valid_r, out_last_r, out_done_r;
  logic [7:0]       out_byte_r;

  logic        accept, fire, gen_state, data_byte, px_end, work_end, last_c, done_c;
  logic [7:0]  byte_c;
  sum_ctl_t    ctl_c;
  logic [31:0] crc_w, adler_w, crc_x;
  logic [12:0] cfg_clamped;
  logic [13:0] col_inc;
  logic        row_wrap;
  logic [12:0] col_after, row_after;
  logic [15:0] blen, nlen;
  logic [XW-1:0]    dv_in;
  logic [XW+MW-1:0] recip_prod;
  logic [31:0] product, blocks;

  // Handshakes
  assign gen_state = (state_r == ST_HDR) || (state_r == ST_RAW) || (state_r == ST_CLOSE);
  assign in_stall  = pend_v_r || ((state_r != ST_IDLE) && !paused_r);
  assign accept    = in_valid && !in_stall;
  assign fire      = gen_state && !paused_r && (!out_valid_r || !out_stall);

  // Register value clamp: zero reads as one, large values saturate
  always_comb begin
    cfg_clamped = (cfg_data == 13'd0) ? 13'd1 : cfg_data;
    if (cfg_index == REG_WIDTH) begin
      if (cfg_clamped > W_MAX) cfg_clamped = W_MAX;
    end else begin
      if (cfg_clamped > H_MAX) cfg_clamped = H_MAX;
    end
  end

  // Pixel position after the current pixel
  assign col_inc   = {1'b0, col_r} + 14'd1;
  assign row_wrap  = (col_inc == {1'b0, width_r});
  assign col_after = row_wrap ? 13'd0 : col_inc[12:0];
  assign row_after = row_wrap ? 13'(row_r + 13'd1) : row_r;

  // Stored block header fields
  assign blen = (left_r > BLK_R) ? 16'(BLOCK_BYTES) : 16'(left_r);
  assign nlen = ~blen;

  // Length arithmetic: the block count is a rounded-up quotient taken by
  // multiplying with the reciprocal of the block size.
  assign dv_in      = XW'(raw_len_r) + XW'(BLOCK_BYTES - 1);
  assign recip_prod = (XW + MW)'(dv_in) * (XW + MW)'(RECIP_M);
  assign product    = 32'(height_r) * (32'd1 + 32'd3 * 32'(width_r));
  assign blocks     = 32'(dv_r);
  assign crc_x      = crc_w ^ CRC_ONES;

  // Byte selection for the running state
  always_comb begin
    byte_c    = 8'h00;
    ctl_c     = '0;
    data_byte = 1'b0;
    done_c    = 1'b0;
    case (state_r)
      ST_HDR: begin
        ctl_c.crc_en   = (idx_r >= 6'd12) && !(idx_r inside {[6'd29:6'd36]});
        ctl_c.crc_init = (idx_r == 6'd12) || (idx_r == 6'd37);
        case (idx_r)
          6'd0:  byte_c = 8'h89;
          6'd1:  byte_c = 8'h50;
          6'd2:  byte_c = 8'h4E;
          6'd3:  byte_c = 8'h47;
          6'd4:  byte_c = 8'h0D;
          6'd5:  byte_c = 8'h0A;
          6'd6:  byte_c = 8'h1A;
          6'd7:  byte_c = 8'h0A;
          6'd11: byte_c = 8'h0D;
          6'd12: byte_c = 8'h49;
          6'd13: byte_c = 8'h48;
          6'd14: byte_c = 8'h44;
          6'd15: byte_c = 8'h52;
          6'd18: byte_c = {3'd0, width_r[12:8]};
          6'd19: byte_c = width_r[7:0];
          6'd22: byte_c = {3'd0, height_r[12:8]};
          6'd23: byte_c = height_r[7:0];
          6'd24: byte_c = 8'h08;
          6'd25: byte_c = 8'h02;
          6'd29: byte_c = crc_x[31:24];
          6'd30: byte_c = crc_x[23:16];
          6'd31: byte_c = crc_x[15:8];
          6'd32: byte_c = crc_x[7:0];
          6'd33: byte_c = idat_r[31:24];
          6'd34: byte_c = idat_r[23:16];
          6'd35: byte_c = idat_r[15:8];
          6'd36: byte_c = idat_r[7:0];
          6'd37: byte_c = 8'h49;
          6'd38: byte_c = 8'h44;
          6'd39: byte_c = 8'h41;
          6'd40: byte_c = 8'h54;
          6'd41: byte_c = 8'h78;
          6'd42: byte_c = 8'h01;
          default: byte_c = 8'h00;
        endcase
      end
      ST_RAW: begin
        ctl_c.crc_en = 1'b1;
        if ((boff_r == '0) && (bhdr_r != BHDR_DONE)) begin
          case (bhdr_r)
            3'd0:    byte_c = (left_r <= BLK_R) ? 8'h01 : 8'h00;
            3'd1:    byte_c = blen[7:0];
            3'd2:    byte_c = blen[15:8];
            3'd3:    byte_c = nlen[7:0];
            default: byte_c = nlen[15:8];
          endcase
        end else begin
          data_byte      = 1'b1;
          ctl_c.adler_en = 1'b1;
          case (sel_r)
            2'd1:    byte_c = red_r;
            2'd2:    byte_c = green_r;
            2'd3:    byte_c = blue_r;
            default: byte_c = 8'h00;
          endcase
        end
      end
      ST_CLOSE: begin
        ctl_c.crc_en   = (idx_r <= 6'd3) || (idx_r inside {[6'd12:6'd15]});
        ctl_c.crc_init = (idx_r == 6'd12);
        done_c         = (idx_r == CLOSE_LAST);
        case (idx_r)
          6'd0:  byte_c = adler_w[31:24];
          6'd1:  byte_c = adler_w[23:16];
          6'd2:  byte_c = adler_w[15:8];
          6'd3:  byte_c = adler_w[7:0];
          6'd4, 6'd16: byte_c = crc_x[31:24];
          6'd5, 6'd17: byte_c = crc_x[23:16];
          6'd6, 6'd18: byte_c = crc_x[15:8];
          6'd7, 6'd19: byte_c = crc_x[7:0];
          6'd12: byte_c = 8'h49;
          6'd13: byte_c = 8'h45;
          6'd14: byte_c = 8'h4E;
          6'd15: byte_c = 8'h44;
          default: byte_c = 8'h00;
        endcase
      end
      default: byte_c = 8'h00;
    endcase
  end

  assign px_end   = data_byte && (sel_r == 2'd3);
  assign work_end = (px_end && !last_px_r) || done_c;
  assign last_c   = (step_cnt_r == OUT_LIMIT - 6'd1) || (work_end && !pend_v_r);

  // Checksum unit
  pngse_sum u_sum (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (fire),
    .ctl   (ctl_c),
    .data  (byte_c),
    .crc   (crc_w),
    .adler (adler_w)
  );

  // Control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      idx_r      <= 6'd0;
      step_cnt_r <= 6'd0;
      bhdr_r     <= 3'd0;
      sel_r      <= 2'd0;
      paused_r   <= 1'b0;
      started_r  <= 1'b0;
      finished_r <= 1'b0;
      last_px_r  <= 1'b0;
      pend_v_r   <= 1'b0;
      col_r      <= 13'd0;
      row_r      <= 13'd0;
      width_r    <= 13'd1;
      height_r   <= 13'd1;
      left_r     <= '0;
      boff_r     <= '0;
    end else begin
      // Register writes before the first pixel
      if (cfg_we && !started_r) begin
        if (cfg_index == REG_WIDTH) width_r <= cfg_clamped;
        else                        height_r <= cfg_clamped;
      end

      // New input transaction
      if (accept) begin
        step_cnt_r <= 6'd0;
        paused_r   <= 1'b0;
        if (!finished_r) begin
          if (state_r != ST_IDLE) begin
            pend_v_r <= 1'b1;
          end else begin
            last_px_r  <= (col_inc == {1'b0, width_r}) && (row_r + 13'd1 == height_r);
            finished_r <= (col_inc == {1'b0, width_r}) && (row_r + 13'd1 == height_r);
            sel_r      <= (col_r == 13'd0) ? 2'd0 : 2'd1;
            bhdr_r     <= 3'd0;
            started_r  <= 1'b1;
            state_r    <= started_r ? ST_RAW : ST_MUL;
          end
        end
      end

      // Length calculation for the first pixel
      case (state_r)
        ST_MUL: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          left_r  <= raw_len_r;
          boff_r  <= '0;
          idx_r   <= 6'd0;
          state_r <= ST_HDR;
        end
        default: ;
      endcase

      // One byte leaves the sequencer
      if (fire) begin
        step_cnt_r <= step_cnt_r + 6'd1;
        if (step_cnt_r == OUT_LIMIT - 6'd1) paused_r <= 1'b1;
        case (state_r)
          ST_HDR: begin
            idx_r <= 6'(idx_r + 6'd1);
            if (idx_r == HDR_LAST) state_r <= ST_RAW;
          end
          ST_RAW: begin
            if (!data_byte) begin
              bhdr_r <= 3'(bhdr_r + 3'd1);
            end else begin
              bhdr_r <= 3'd0;
              boff_r <= (boff_r == BOFF_LAST) ? '0 : BW'(boff_r + 1'b1);
              if (left_r != '0) left_r <= RAW_W'(left_r - 1'b1);
              if (!px_end) sel_r <= 2'(sel_r + 2'd1);
              if (px_end) begin
                col_r <= col_after;
                row_r <= row_after;
                if (last_px_r) begin
                  idx_r   <= 6'd0;
                  state_r <= ST_CLOSE;
                end else if (pend_v_r) begin
                  pend_v_r   <= 1'b0;
                  last_px_r  <= ({1'b0, col_after} + 14'd1 == {1'b0, width_r}) &&
                                (row_after + 13'd1 == height_r);
                  finished_r <= ({1'b0, col_after} + 14'd1 == {1'b0, width_r}) &&
                                (row_after + 13'd1 == height_r);
                  sel_r      <= (col_after == 13'd0) ? 2'd0 : 2'd1;
                end else begin
                  state_r <= ST_IDLE;
                end
              end
            end
          end
          ST_CLOSE: begin
            idx_r <= 6'(idx_r + 6'd1);
            if (idx_r == CLOSE_LAST) state_r <= ST_IDLE;
          end
          default: ;
        endcase
      end
    end
  end

  // Pixel holding registers and the length datapath
  always_ff @(posedge clk) begin
    if (accept && !finished_r) begin
      if (state_r != ST_IDLE) begin
        pred_r   <= in_red;
        pgreen_r <= in_green;
        pblue_r  <= in_blue;
      end else begin
        red_r   <= in_red;
        green_r <= in_green;
        blue_r  <= in_blue;
      end
    end else if (fire && px_end && !last_px_r && pend_v_r) begin
      red_r   <= pred_r;
      green_r <= pgreen_r;
      blue_r  <= pblue_r;
    end
    case (state_r)
      ST_MUL: begin
        raw_len_r <= RAW_W'(product);
      end
      ST_DIV: begin
        dv_r <= XW'(recip_prod >> SH);
      end
      ST_SUM: begin
        idat_r <= 32'd6 + 32'(raw_len_r) + (blocks << 2) + blocks;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r <= byte_c;
      out_last_r <= last_c;
      out_done_r <= done_c;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_last_of_item = out_last_r;
  assign out_file_done    = out_done_r;

`ifndef ASSERT_OFF
  // A held pixel always blocks the input.
  a_pend_stall: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> in_stall)
    else $error("pending pixel without input stall");

  // The final byte of the file also closes its transaction.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_file_done) |-> out_last_of_item)
    else $error("file end byte not marked last of transaction");

  // The sequencer pauses only after a full burst.
  a_pause_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    paused_r |-> (step_cnt_r == OUT_LIMIT))
    else $error("pause without a full burst");

  // Image size is frozen once the file has started.
  a_cfg_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (started_r && cfg_we) |=> ($stable(width_r) && $stable(height_r)))
    else $error("image size changed after start");
`endif

endmodule
